@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the touch report parser modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define TPR_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define TPR_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/tpr_pkg.sv @@
package tpr_pkg;

  localparam int REPORT_BYTES = 43;
  localparam int TOUCH_SLOTS  = 5;
  localparam int SLOT_AREA    = 4 * TOUCH_SLOTS;

  localparam int COUNT_W = $clog2(REPORT_BYTES);
  localparam int SLOT_W  = (TOUCH_SLOTS > 1) ? $clog2(TOUCH_SLOTS) : 1;

  localparam logic [7:0]  ID_RESET     = 8'h5A;
  localparam logic [12:0] WIDTH_RESET  = 13'd720;
  localparam logic [12:0] HEIGHT_RESET = 13'd1440;
  localparam logic [7:0]  EMPTY_BYTE   = 8'hFF;

  typedef enum logic [1:0] {
    CFG_REPORT_ID  = 2'd0,
    CFG_LCD_WIDTH  = 2'd1,
    CFG_LCD_HEIGHT = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    ST_POINT   = 2'd0,
    ST_RELEASE = 2'd1,
    ST_BAD_ID  = 2'd2,
    ST_BAD_CHK = 2'd3
  } result_kind_t;

  typedef enum logic [2:0] {
    S_RECV,
    S_CHECK,
    S_SCAN,
    S_MAP,
    S_LOAD,
    S_SINGLE
  } tpr_state_t;

  typedef struct packed {
    logic accept;
    logic start_scan;
    logic next_slot;
    logic map;
    logic load_point;
    logic load_single;
    logic set_active;
    logic clr_active;
  } tpr_cmd_t;

  typedef struct packed {
    logic frame_end;
    logic id_ok;
    logic chk_ok;
    logic any_active;
    logic was_active;
    logic cur_active;
    logic cur_last;
    logic out_free;
  } tpr_sts_t;

  // Scales a 12-bit raw coordinate to the display size, clamped to 12 bits.
  function automatic logic [11:0] map_coord(logic [11:0] raw, logic [12:0] size);
    logic [24:0] prod;
    logic [13:0] v;
    prod = {13'd0, raw} * {12'd0, size};
    if (raw[11]) begin
      v = (size == 13'd0) ? 14'd0 : {1'b0, size - 13'd1};
    end else begin
      v = prod[24:11];
    end
    return (v > 14'd4095) ? 12'hFFF : v[11:0];
  endfunction

  function automatic logic [2:0] slot_field(logic [SLOT_W-1:0] idx);
    return 3'(idx);
  endfunction

endpackage

@@ rtl/touch_report_parser_core.sv @@
// Touch report parser. Bytes of a fixed-length report (43 bytes: report ID,
// five 4-byte touch slots, padding, checksum) enter one per beat on the s_
// stream, with s_tuser marking the first byte of a report. s_tready stays
// high while a report is being received; a start flag in mid-report drops
// the partial report silently, and stray bytes outside a report are ignored.
// After the checksum byte the block checks the report in a check state, with
// s_tready low, and then emits its results on the m_ stream. A bad ID or bad
// checksum gives one status beat, and a touch-free report that follows one
// with touches gives one release beat; either then passes through a load
// state. A good report gives one beat per active slot, and each active slot
// passes through a scan state, a coordinate-scaling state using the two 12x13
// multipliers and a load state, plus a scan state per empty slot skipped
// before the last active one. A touch-free report that owes nothing goes
// back to receiving straight after the check. m_tlast marks the final beat
// of a report. A result waits in an output register, so a new report starts
// as soon as the last result is loaded; a stalled consumer holds the block
// only while a further result has to be loaded behind one that has not been
// taken yet. Configuration writes (report ID, display width, display height)
// are always taken and should only be issued while idle.
module touch_report_parser_core import tpr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // Input bytes.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] frame_start
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  // Results.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [2:0] slot, [14:3] raw_x, [26:15] raw_y,
                                 // [38:27] lcd_x, [50:39] lcd_y, [58:51] pressure
  output logic [1:0]  m_tuser,   // [1:0] status
  output logic        m_tlast    // [0] last
);

  tpr_cmd_t cmd;
  tpr_sts_t sts;

  // Configuration registers are plain flops, so a write never has to wait.
  assign cfg_ready = 1'b1;

  tpr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tpr_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

@@ rtl/tpr_ctrl.sv @@
`include "assert_macros.svh"

module tpr_ctrl import tpr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  input  tpr_sts_t sts,
  output tpr_cmd_t cmd
);

  tpr_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RECV;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_RECV: begin
        if (s_tvalid && sts.frame_end) state_next = S_CHECK;
      end
      S_CHECK: begin
        priority if (!sts.id_ok || !sts.chk_ok) state_next = S_SINGLE;
        else if (sts.any_active) state_next = S_SCAN;
        else if (sts.was_active) state_next = S_SINGLE;
        else state_next = S_RECV;
      end
      S_SCAN: begin
        if (sts.cur_active) state_next = S_MAP;
      end
      S_MAP: begin
        state_next = S_LOAD;
      end
      S_LOAD: begin
        if (sts.out_free) state_next = sts.cur_last ? S_RECV : S_SCAN;
      end
      S_SINGLE: begin
        if (sts.out_free) state_next = S_RECV;
      end
      default: state_next = S_RECV;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      S_RECV: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
      end
      S_CHECK: begin
        cmd.start_scan = 1'b1;
        if (sts.id_ok && sts.chk_ok) begin
          cmd.set_active = sts.any_active;
          cmd.clr_active = !sts.any_active && sts.was_active;
        end
      end
      S_SCAN: begin
        cmd.next_slot = !sts.cur_active;
      end
      S_MAP: begin
        cmd.map = 1'b1;
      end
      S_LOAD: begin
        cmd.load_point = sts.out_free;
        cmd.next_slot  = sts.out_free && !sts.cur_last;
      end
      S_SINGLE: begin
        cmd.load_single = sts.out_free;
      end
      default: cmd = '0;
    endcase
  end

  `TPR_NEXT(a_end_check, clk, rst, (cmd.accept && sts.frame_end), (state == S_CHECK), "final byte did not lead to the check step")
  `TPR_IMPLY(a_load_free, clk, rst, (cmd.load_point || cmd.load_single), sts.out_free, "result loaded over an untaken result")

endmodule

@@ rtl/tpr_dp.sv @@
`include "assert_macros.svh"

module tpr_dp import tpr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  tpr_cmd_t    cmd,
  output tpr_sts_t    sts,
  input  logic [7:0]  s_tdata,
  input  logic        s_tuser,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        m_tready,
  output logic        m_tvalid,
  output logic [63:0] m_tdata,
  output logic [1:0]  m_tuser,
  output logic        m_tlast
);

  logic [7:0]  report_id;
  logic [12:0] lcd_width;
  logic [12:0] lcd_height;

  logic [COUNT_W-1:0] byte_count;
  logic [7:0]         running_sum;
  logic               in_frame;
  logic               id_matched;
  logic               chk_ok;
  logic               was_active;

  logic [3:0][7:0] slot_mem [TOUCH_SLOTS];
  logic [TOUCH_SLOTS-1:0] act_mask;
  logic [TOUCH_SLOTS-1:0] act_now;
  logic [SLOT_W-1:0]      slot_idx;

  logic [11:0] map_x;
  logic [11:0] map_y;

  logic         out_valid;
  result_kind_t out_kind;
  logic [2:0]   out_slot;
  logic [11:0]  out_raw_x;
  logic [11:0]  out_raw_y;
  logic [11:0]  out_lcd_x;
  logic [11:0]  out_lcd_y;
  logic [7:0]   out_pressure;
  logic         out_last;

  logic               eff_in;
  logic [COUNT_W-1:0] pos;
  logic [7:0]         sum_base;
  logic [7:0]         sum_next;
  logic               in_area;
  logic [COUNT_W-1:0] widx;
  logic [SLOT_W-1:0]  wrow;
  logic [1:0]         wlane;
  logic [11:0]        cur_rx;
  logic [11:0]        cur_ry;
  logic               cur_last;

  // A start flag restarts the count and the sum on this very byte.
  assign eff_in   = s_tuser || in_frame;
  assign pos      = s_tuser ? '0 : byte_count;
  assign sum_base = s_tuser ? 8'd0 : running_sum;
  assign sum_next = sum_base + s_tdata;
  assign in_area  = (pos != '0) && (32'(pos) <= SLOT_AREA);
  assign widx     = pos - COUNT_W'(1);
  assign wrow     = SLOT_W'(widx >> 2);
  assign wlane    = widx[1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      report_id  <= ID_RESET;
      lcd_width  <= WIDTH_RESET;
      lcd_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REPORT_ID:  report_id  <= cfg_data[7:0];
        CFG_LCD_WIDTH:  lcd_width  <= cfg_data;
        CFG_LCD_HEIGHT: lcd_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= '0;
      running_sum <= '0;
      in_frame    <= 1'b0;
      id_matched  <= 1'b0;
      chk_ok      <= 1'b0;
    end else if (cmd.accept && eff_in) begin
      if (pos == '0) id_matched <= (s_tdata == report_id);
      if (sts.frame_end) begin
        in_frame   <= 1'b0;
        byte_count <= '0;
        chk_ok     <= (sum_next == 8'd0);
      end else begin
        in_frame    <= 1'b1;
        byte_count  <= pos + COUNT_W'(1);
        running_sum <= sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && eff_in && in_area) begin
      slot_mem[wrow][wlane] <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      was_active <= 1'b0;
    end else if (cmd.set_active) begin
      was_active <= 1'b1;
    end else if (cmd.clr_active) begin
      was_active <= 1'b0;
    end
  end

  always_comb begin
    for (int i = 0; i < TOUCH_SLOTS; i++) begin
      act_now[i] = !((slot_mem[i][0] == EMPTY_BYTE) && (slot_mem[i][1] == EMPTY_BYTE) &&
                     (slot_mem[i][2] == EMPTY_BYTE));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_scan) begin
      act_mask <= act_now;
      slot_idx <= '0;
    end else if (cmd.next_slot) begin
      slot_idx <= slot_idx + SLOT_W'(1);
    end
  end

  always_comb begin
    cur_last = 1'b1;
    for (int j = 0; j < TOUCH_SLOTS; j++) begin
      if ((j > 32'(slot_idx)) && act_mask[j]) cur_last = 1'b0;
    end
  end

  assign cur_rx = {slot_mem[slot_idx][0][7:4], slot_mem[slot_idx][1]};
  assign cur_ry = {slot_mem[slot_idx][0][3:0], slot_mem[slot_idx][2]};

  always_ff @(posedge clk) begin
    if (cmd.map) begin
      map_x <= map_coord(cur_rx, lcd_width);
      map_y <= map_coord(cur_ry, lcd_height);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_point || cmd.load_single) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_point) begin
      out_kind     <= ST_POINT;
      out_slot     <= slot_field(slot_idx);
      out_raw_x    <= cur_rx;
      out_raw_y    <= cur_ry;
      out_lcd_x    <= map_x;
      out_lcd_y    <= map_y;
      out_pressure <= slot_mem[slot_idx][3];
      out_last     <= cur_last;
    end else if (cmd.load_single) begin
      priority if (!id_matched) out_kind <= ST_BAD_ID;
      else if (!chk_ok) out_kind <= ST_BAD_CHK;
      else out_kind <= ST_RELEASE;
      out_slot     <= '0;
      out_raw_x    <= '0;
      out_raw_y    <= '0;
      out_lcd_x    <= '0;
      out_lcd_y    <= '0;
      out_pressure <= '0;
      out_last     <= 1'b1;
    end
  end

  assign sts.frame_end  = eff_in && (pos >= COUNT_W'(REPORT_BYTES - 1));
  assign sts.id_ok      = id_matched;
  assign sts.chk_ok     = chk_ok;
  assign sts.any_active = |act_now;
  assign sts.was_active = was_active;
  assign sts.cur_active = act_mask[slot_idx];
  assign sts.cur_last   = cur_last;
  assign sts.out_free   = !out_valid || m_tready;

  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;
  assign m_tdata  = {5'd0, out_pressure, out_lcd_y, out_lcd_x, out_raw_y, out_raw_x, out_slot};

  `TPR_IMPLY(a_point_active, clk, rst, cmd.load_point, act_mask[slot_idx], "touch point sent for an empty slot")
  `TPR_IMPLY(a_single_zero, clk, rst, (out_valid && (out_kind != ST_POINT)), (out_last && (m_tdata == 64'd0)), "status result carries point data")

endmodule

@@ dv/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tpr_pkg::*;

  // Wait allowed after the last expected beat for the check and scan
  // pipeline to go quiet.
  localparam int SETTLE_CYCLES = 60;
  // Length of the long consumer hold-off used to fill the output side.
  localparam int HOLD_CYCLES   = 400;
  // Position of the checksum byte within a report.
  localparam int CHK_POS       = REPORT_BYTES - 1;

  // One result beat as the parser should present it.
  typedef struct {
    result_kind_t kind;
    logic [2:0]   slot;
    logic [11:0]  raw_x;
    logic [11:0]  raw_y;
    logic [11:0]  lcd_x;
    logic [11:0]  lcd_y;
    logic [7:0]   pressure;
    logic         last;
  } touch_result_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [12:0] cfg_data;
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  touch_report_parser_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  // Shadow copy of the parser: the display settings it should hold and the
  // report it is in the middle of receiving.
  logic [7:0]  cur_report_id;
  logic [12:0] cur_lcd_width;
  logic [12:0] cur_lcd_height;
  int          byte_pos;
  logic [7:0]  byte_sum;
  logic        id_ok;
  logic        in_report;
  logic        had_touch;
  logic [7:0]  slot_mem [SLOT_AREA];

  // Result beats that the reports sent so far still owe, oldest first.
  touch_result_t report_results_q [$];

  // Report under construction by the stimulus side.
  logic [7:0] frame_buf [REPORT_BYTES];

  // Run controls and statistics.
  bit idle_on;
  int hold_request;
  int mismatches;
  int beats_checked;
  int useful_bytes;
  int reports_seen;
  int points_seen;
  int releases_seen;
  int rejects_seen;
  int settings_used;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Safety net: even the slowest legal run ends far before this.
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------

  // Scales a raw coordinate to the display size. Raw values in the upper
  // half of the 12-bit range pin to the last pixel; the result saturates
  // to twelve bits.
  function automatic logic [11:0] scale_to_lcd(logic [11:0] raw, logic [12:0] size);
    int unsigned v;
    if (raw >= 12'd2048) begin
      v = (size == 13'd0) ? 0 : int'(size) - 1;
    end else begin
      v = (int'(raw) * int'(size)) >> 11;
    end
    if (v > 4095) v = 4095;
    return 12'(v);
  endfunction

  // A status-only beat: every data field is zero and it closes the report.
  function automatic touch_result_t blank_result(result_kind_t kind);
    touch_result_t r;
    r.kind     = kind;
    r.slot     = '0;
    r.raw_x    = '0;
    r.raw_y    = '0;
    r.lcd_x    = '0;
    r.lcd_y    = '0;
    r.pressure = '0;
    r.last     = 1'b1;
    return r;
  endfunction

  function automatic int results_predicted();
    return points_seen + releases_seen + rejects_seen;
  endfunction

  // Works out what the checksum byte of a report produces. The ID is judged
  // before the checksum, and neither kind of rejection touches the memory of
  // whether the previous good report had touches.
  task automatic close_report(input logic [7:0] check);
    touch_result_t r;
    touch_result_t points [$];
    logic [7:0]    a;
    logic [7:0]    b;
    logic [7:0]    c;
    logic [7:0]    total;
    reports_seen++;
    total = check + byte_sum;
    if (!id_ok) begin
      report_results_q.push_back(blank_result(ST_BAD_ID));
      rejects_seen++;
    end else if (total != 8'd0) begin
      report_results_q.push_back(blank_result(ST_BAD_CHK));
      rejects_seen++;
    end else begin
      for (int i = 0; i < TOUCH_SLOTS; i++) begin
        a = slot_mem[4*i];
        b = slot_mem[4*i+1];
        c = slot_mem[4*i+2];
        // A slot is only empty when all three coordinate bytes are 0xFF.
        if (!(a == EMPTY_BYTE && b == EMPTY_BYTE && c == EMPTY_BYTE)) begin
          r          = blank_result(ST_POINT);
          r.last     = 1'b0;
          r.slot     = 3'(i);
          r.raw_x    = {a[7:4], b};
          r.raw_y    = {a[3:0], c};
          r.lcd_x    = scale_to_lcd(r.raw_x, cur_lcd_width);
          r.lcd_y    = scale_to_lcd(r.raw_y, cur_lcd_height);
          r.pressure = slot_mem[4*i+3];
          points.push_back(r);
        end
      end
      if (points.size() != 0) begin
        points[points.size()-1].last = 1'b1;
        foreach (points[k]) report_results_q.push_back(points[k]);
        points_seen += points.size();
        had_touch = 1'b1;
      end else if (had_touch) begin
        // First touch-free report after touches: a single release beat.
        report_results_q.push_back(blank_result(ST_RELEASE));
        releases_seen++;
        had_touch = 1'b0;
      end
    end
  endtask

  // Follows one accepted input byte through the report framing.
  task automatic track_report_byte(input logic [7:0] value, input logic first);
    if (first) begin
      // A start flag always opens a fresh report, dropping any partial one.
      byte_pos  = 0;
      byte_sum  = '0;
      in_report = 1'b1;
    end
    // Bytes outside a report are stray and change nothing.
    if (in_report) begin
      useful_bytes++;
      if (byte_pos == 0) id_ok = (value == cur_report_id);
      if (byte_pos >= 1 && byte_pos <= SLOT_AREA) slot_mem[byte_pos-1] = value;
      if (byte_pos >= CHK_POS) begin
        in_report = 1'b0;
        byte_pos  = 0;
        close_report(value);
      end else begin
        byte_sum += value;
        byte_pos++;
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      mismatches++;
    end
  endfunction

  // Every result beat is matched against the oldest outstanding prediction.
  // Sampling at the edge sees the values the parser itself used there.
  always @(posedge clk) begin : result_check
    touch_result_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (report_results_q.size() == 0) begin
        $error("result beat with nothing expected: status %0d", m_tuser);
        mismatches++;
      end else begin
        exp_r = report_results_q.pop_front();
        check_field("status",   exp_r.kind,     m_tuser);
        check_field("slot",     exp_r.slot,     m_tdata[2:0]);
        check_field("raw_x",    exp_r.raw_x,    m_tdata[14:3]);
        check_field("raw_y",    exp_r.raw_y,    m_tdata[26:15]);
        check_field("lcd_x",    exp_r.lcd_x,    m_tdata[38:27]);
        check_field("lcd_y",    exp_r.lcd_y,    m_tdata[50:39]);
        check_field("pressure", exp_r.pressure, m_tdata[58:51]);
        check_field("last",     exp_r.last,     m_tlast);
        beats_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Consumer side
  // ---------------------------------------------------------------------

  // The result consumer accepts most of the time, drops out in random
  // bursts while idling is enabled, and on request holds off for a long,
  // counted stretch so that the parser backs up into its input.
  initial begin
    m_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        m_tready <= 1'b0;
        repeat (hold_request) @(posedge clk);
        hold_request = 0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // Offers one byte and waits for its beat. Valid stays high into the next
  // byte unless an idle burst is inserted first.
  task automatic offer_byte(input logic [7:0] value, input logic first);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    s_tuser  <= first;
    do @(posedge clk); while (!s_tready);
    track_report_byte(value, first);
  endtask

  // Coordinates favor the corners of the range and the clamp boundary.
  function automatic logic [11:0] pick_raw();
    case ($urandom_range(0, 7))
      0:       return 12'h000;
      1:       return 12'hFFF;
      2:       return 12'd2047;
      3:       return 12'd2048;
      default: return 12'($urandom);
    endcase
  endfunction

  function automatic logic [TOUCH_SLOTS-1:0] random_mask();
    if ($urandom_range(0, 5) == 0) return '0;
    return TOUCH_SLOTS'($urandom);
  endfunction

  function automatic void put_slot(int idx, logic [11:0] x, logic [11:0] y, logic [7:0] p);
    frame_buf[4*idx+1] = {x[11:8], y[11:8]};
    frame_buf[4*idx+2] = x[7:0];
    frame_buf[4*idx+3] = y[7:0];
    frame_buf[4*idx+4] = p;
  endfunction

  // Empty slot marker; the pressure byte of an empty slot is don't-care.
  function automatic void clear_slot(int idx);
    put_slot(idx, 12'hFFF, 12'hFFF, 8'($urandom));
  endfunction

  // Builds a report with the given ID and touch slots; padding is random.
  function automatic void fill_frame(logic [7:0] id, logic [TOUCH_SLOTS-1:0] mask);
    frame_buf[0] = id;
    for (int i = SLOT_AREA + 1; i < REPORT_BYTES; i++) frame_buf[i] = 8'($urandom);
    for (int i = 0; i < TOUCH_SLOTS; i++) begin
      if (mask[i]) put_slot(i, pick_raw(), pick_raw(), 8'($urandom));
      else clear_slot(i);
    end
  endfunction

  // Fills in the checksum byte, optionally spoiling it.
  function automatic void seal_frame(bit bad);
    logic [7:0] sum;
    sum = '0;
    for (int i = 0; i < CHK_POS; i++) sum += frame_buf[i];
    frame_buf[CHK_POS] = 8'd0 - sum;
    if (bad) frame_buf[CHK_POS] ^= 8'($urandom_range(1, 255));
  endfunction

  // Sends the first len bytes of the report buffer, flagging byte 0.
  task automatic send_report(input int len);
    for (int i = 0; i < len; i++) offer_byte(frame_buf[i], i == 0);
  endtask

  task automatic send_frame(input logic [7:0] id, input logic [TOUCH_SLOTS-1:0] mask,
                            input bit bad_chk);
    fill_frame(id, mask);
    seal_frame(bad_chk);
    send_report(REPORT_BYTES);
  endtask

  // Brings the parser to rest: any open report is replaced by a complete one,
  // every owed beat is collected, and the scan pipeline gets time to finish a
  // report that owes nothing.
  task automatic drain_results();
    if (in_report) send_frame(cur_report_id, random_mask(), 1'b0);
    s_tvalid <= 1'b0;
    while (report_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all three display registers back to back; call only at rest.
  task automatic program_display(input logic [7:0] id, input logic [12:0] w,
                                 input logic [12:0] h);
    cfg_index_t  idx [3];
    logic [12:0] val [3];
    idx = '{CFG_REPORT_ID, CFG_LCD_WIDTH, CFG_LCD_HEIGHT};
    val = '{{5'd0, id}, w, h};
    cfg_valid <= 1'b1;
    for (int k = 0; k < 3; k++) begin
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid      <= 1'b0;
    cur_report_id  = id;
    cur_lcd_width  = w;
    cur_lcd_height = h;
    settings_used++;
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Coordinate and pressure extremes, the clamp boundary on both axes, and
  // slots that are only partly 0xFF, which still count as touches.
  task automatic test_touch_extremes();
    fill_frame(cur_report_id, '1);
    put_slot(0, 12'h000, 12'h000, 8'h00);
    put_slot(1, 12'hFFF, 12'hFFE, 8'hFF);
    put_slot(2, 12'd2047, 12'd2048, 8'h80);
    put_slot(3, 12'd2048, 12'd2047, 8'h01);
    put_slot(4, 12'hFFF, 12'hF00, 8'h7F);
    seal_frame(1'b0);
    send_report(REPORT_BYTES);
  endtask

  // Rejections while touches are active must not clear that memory, so the
  // next clean touch-free report still produces a release, and the one after
  // it stays silent. A report that is wrong in both ID and checksum reports
  // the ID.
  task automatic test_report_errors();
    send_frame(cur_report_id, '1, 1'b1);
    send_frame(cur_report_id ^ 8'h80, '1, 1'b1);
    send_frame(cur_report_id, '0, 1'b0);
    send_frame(cur_report_id, '0, 1'b0);
  endtask

  // Stray bytes outside a report, and restarts that drop a partial report
  // early and on the checksum byte itself.
  task automatic test_restart_and_stray();
    repeat (3) offer_byte(8'($urandom), 1'b0);
    fill_frame(cur_report_id, '1);
    seal_frame(1'b0);
    send_report(10);
    fill_frame(cur_report_id, '1);
    seal_frame(1'b0);
    send_report(CHK_POS);
    send_frame(cur_report_id, 5'b10001, 1'b0);
    repeat (2) offer_byte(8'($urandom), 1'b0);
  endtask

  // Sets the display registers to a width of 4096 and a height of 1, with a
  // new report ID, and sends a full report.
  task automatic test_display_settings();
    drain_results();
    program_display(8'hA5, 13'd4096, 13'd1);
    send_frame(cur_report_id, '1, 1'b0);
  endtask

  // The consumer stops for a long stretch while full reports keep coming,
  // so the output register fills and the parser has to stall its input.
  task automatic test_backpressure();
    hold_request = HOLD_CYCLES;
    repeat (2) send_frame(cur_report_id, '1, 1'b0);
  endtask

  // Mostly well-formed reports with random touches, mixed with rejected
  // reports, truncated reports, raw noise and fully random slot contents.
  task automatic run_random_traffic(input int byte_goal, input int result_goal);
    int bytes0;
    int results0;
    int pick;
    bytes0   = useful_bytes;
    results0 = results_predicted();
    while (useful_bytes - bytes0 < byte_goal ||
           results_predicted() - results0 < result_goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        send_frame(cur_report_id, random_mask(), 1'b0);
      end else if (pick < 68) begin
        send_frame(cur_report_id ^ 8'($urandom_range(1, 255)), random_mask(), 1'b0);
      end else if (pick < 76) begin
        send_frame(cur_report_id, random_mask(), 1'b1);
      end else if (pick < 84) begin
        fill_frame(cur_report_id, random_mask());
        seal_frame(1'b0);
        send_report($urandom_range(1, CHK_POS));
      end else if (pick < 92) begin
        repeat ($urandom_range(1, 6)) offer_byte(8'($urandom), $urandom_range(0, 7) == 0);
      end else begin
        for (int i = 1; i < REPORT_BYTES; i++) frame_buf[i] = 8'($urandom);
        frame_buf[0] = cur_report_id;
        seal_frame(1'b0);
        send_report(REPORT_BYTES);
      end
    end
  endtask

  // Closing stretch with neither side ever pausing.
  task automatic test_full_rate();
    run_random_traffic(40, 0);
  endtask

  // ---------------------------------------------------------------------
  // Sequencing
  // ---------------------------------------------------------------------

  initial begin
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_REPORT_ID;
    cfg_data  <= '0;
    rst       <= 1'b1;
    // The shadow copy starts from the parser's reset state.
    cur_report_id  = ID_RESET;
    cur_lcd_width  = WIDTH_RESET;
    cur_lcd_height = HEIGHT_RESET;
    byte_pos       = 0;
    byte_sum       = '0;
    id_ok          = 1'b0;
    in_report      = 1'b0;
    had_touch      = 1'b0;
    idle_on        = 1'b1;
    hold_request   = 0;
    settings_used  = 1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_touch_extremes();
    test_report_errors();
    test_restart_and_stray();
    test_display_settings();
    test_backpressure();
    idle_on = 1'b0;
    test_full_rate();
    drain_results();

    $display("Covered %0d reports: %0d touch points, %0d releases, %0d rejections, %0d settings.",
             reports_seen, points_seen, releases_seen, rejects_seen, settings_used);
    $display("Checked %0d result beats, %0d field mismatches.", beats_checked, mismatches);
    if (mismatches == 0 && report_results_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/tpr_pkg.sv
rtl/tpr_ctrl.sv
rtl/tpr_dp.sv
rtl/touch_report_parser_core.sv
dv/testbench.sv
